@@ design/sbp_pkg.sv @@
// Shared types, constants and helpers for the sample byte packetizer.
`timescale 1ns / 1ps

package sbp_pkg;

    localparam int RING_BYTES_DEFAULT    = 512;
    localparam int PAYLOAD_BYTES_DEFAULT = 27;
    localparam int CMD_DEPTH_DEFAULT     = 4;

    localparam int ADDR_W   = 9;
    localparam int CHAN_W   = 5;
    localparam int FILL_W   = 5;
    localparam int COUNT_W  = 8;
    localparam int STEP_W   = 3;
    localparam int SLOT_BYTES = 32;

    // Steps of a closing packet: payload byte, header, four trailer bytes.
    localparam logic [STEP_W-1:0] STEP_PAYLOAD = 3'd0;
    localparam logic [STEP_W-1:0] STEP_HEADER  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_TRAIL0  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_TRAIL1  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_TRAIL2  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LAST    = 3'd5;

    localparam logic [15:0] TRAILER_LO = 16'hfdb9;
    localparam logic [15:0] TRAILER_HI = 16'h7531;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_BYTE   = 2'd1,
        CMD_PACKET = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    function automatic logic [7:0] trailer_byte(input logic [STEP_W-1:0] step);
        logic [7:0] b;
        case (step)
            STEP_TRAIL0: b = TRAILER_LO[7:0];
            STEP_TRAIL1: b = TRAILER_LO[15:8];
            STEP_TRAIL2: b = TRAILER_HI[7:0];
            default:     b = TRAILER_HI[15:8];
        endcase
        return b;
    endfunction

endpackage

@@ design/sbp_front.sv @@
// Front end: takes sample items, tracks mux position and payload fill, issues commands.
`timescale 1ns / 1ps

module sbp_front #(
    parameter int PAYLOAD_BYTES = sbp_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic                      mode,
    input  logic signed [15:0]        sample_a,
    input  logic signed [15:0]        sample_b,
    input  logic [sbp_pkg::CHAN_W-1:0] selected_channel,
    input  logic                      cmd_full,
    output logic                      cmd_wr,
    output sbp_pkg::cmd_t             cmd_data
);

    logic [sbp_pkg::CHAN_W-1:0] position_reg;
    logic [sbp_pkg::CHAN_W-1:0] position_next;
    logic [sbp_pkg::FILL_W-1:0] fill_reg;
    logic [sbp_pkg::FILL_W-1:0] fill_next;
    logic [sbp_pkg::FILL_W-1:0] fill_inc;
    logic                       accept;
    logic                       hit;
    logic [15:0]                picked;

    assign accept   = push && !cmd_full;
    // Only the lower half of the mux cycle carries packable samples.
    assign hit      = !position_reg[4] && (selected_channel[3:0] == position_reg[3:0]);
    assign picked   = selected_channel[4] ? sample_b : sample_a;
    assign fill_inc = fill_reg + sbp_pkg::FILL_W'(1);

    always_comb
    begin
        position_next = position_reg;
        fill_next     = fill_reg;
        cmd_wr        = 1'b0;
        cmd_data.kind = sbp_pkg::CMD_BYTE;
        cmd_data.data = picked[11:4];
        if (accept)
        begin
            if (mode)
            begin
                cmd_wr        = 1'b1;
                cmd_data.kind = sbp_pkg::CMD_CLEAR;
            end
            else
            begin
                position_next = position_reg + sbp_pkg::CHAN_W'(1);
                if (hit)
                begin
                    cmd_wr = 1'b1;
                    if (fill_inc == sbp_pkg::FILL_W'(PAYLOAD_BYTES))
                    begin
                        cmd_data.kind = sbp_pkg::CMD_PACKET;
                        fill_next     = '0;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            position_reg <= position_next;
            fill_reg     <= fill_next;
        end
    end

endmodule

@@ design/sbp_cmd_fifo.sv @@
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module sbp_cmd_fifo #(
    parameter int DEPTH = sbp_pkg::CMD_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  sbp_pkg::cmd_t wr_data,
    input  logic          rd,
    output sbp_pkg::cmd_t rd_data,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sbp_pkg::cmd_t     entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                               : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ design/sbp_back.sv @@
// Back end: writes payload, header and trailer bytes with ring addresses.
`timescale 1ns / 1ps

module sbp_back #(
    parameter int RING_BYTES = sbp_pkg::RING_BYTES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [sbp_pkg::CHAN_W-1:0]  selected_channel,
    input  logic                        cmd_empty,
    input  sbp_pkg::cmd_t               cmd_head,
    output logic                        cmd_rd,
    output logic                        mid_packet,
    input  logic                        pop,
    output logic                        empty,
    output logic [7:0]                  data_byte,
    output logic [sbp_pkg::ADDR_W-1:0]  byte_address,
    output logic                        last_of_run
);

    localparam int AW = sbp_pkg::ADDR_W;

    logic [sbp_pkg::STEP_W-1:0]  step_reg;
    logic [sbp_pkg::STEP_W-1:0]  step_next;
    logic [sbp_pkg::COUNT_W-1:0] count_reg;
    logic [sbp_pkg::COUNT_W-1:0] count_next;
    logic [AW-1:0]               addr_reg;
    logic [AW-1:0]               addr_next;
    logic [AW-1:0]               slot_reg;
    logic [AW-1:0]               slot_next;
    logic                        out_valid_reg;
    logic [7:0]                  data_reg;
    logic [AW-1:0]               out_addr_reg;
    logic                        last_reg;

    logic                        out_ready;
    logic                        emit;
    logic [7:0]                  emit_byte;
    logic                        emit_last;
    logic [AW-1:0]               addr_inc;
    logic [AW:0]                 slot_sum;
    logic [AW:0]                 realign_sum;
    logic [7:0]                  header_byte;

    assign out_ready   = !out_valid_reg || pop;
    assign addr_inc    = (addr_reg == AW'(RING_BYTES - 1)) ? '0 : addr_reg + AW'(1);
    assign header_byte = count_reg + {selected_channel, 3'b000};
    // Slot offset tracks 32 * count modulo the ring size.
    assign slot_sum    = {1'b0, slot_reg} + (AW + 1)'(sbp_pkg::SLOT_BYTES);
    assign realign_sum = {1'b0, addr_inc[8], 8'h00} + {1'b0, slot_next};
    assign mid_packet  = (step_reg != sbp_pkg::STEP_PAYLOAD);

    always_comb
    begin
        step_next  = step_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        slot_next  = slot_reg;
        cmd_rd     = 1'b0;
        emit       = 1'b0;
        emit_last  = 1'b0;
        case (step_reg)
            sbp_pkg::STEP_PAYLOAD: emit_byte = cmd_head.data;
            sbp_pkg::STEP_HEADER:  emit_byte = header_byte;
            default:               emit_byte = sbp_pkg::trailer_byte(step_reg);
        endcase
        if (!cmd_empty)
        begin
            if (cmd_head.kind == sbp_pkg::CMD_CLEAR)
            begin
                // Clear needs no output slot; retire it at once.
                cmd_rd     = 1'b1;
                count_next = '0;
                slot_next  = '0;
            end
            else if (out_ready)
            begin
                emit      = 1'b1;
                addr_next = addr_inc;
                if (cmd_head.kind == sbp_pkg::CMD_BYTE)
                begin
                    emit_last = 1'b1;
                    cmd_rd    = 1'b1;
                end
                else if (step_reg == sbp_pkg::STEP_LAST)
                begin
                    emit_last  = 1'b1;
                    cmd_rd     = 1'b1;
                    step_next  = sbp_pkg::STEP_PAYLOAD;
                    count_next = count_reg + sbp_pkg::COUNT_W'(1);
                    if (count_reg == '1)
                    begin
                        slot_next = '0;
                    end
                    else if (slot_sum >= (AW + 1)'(RING_BYTES))
                    begin
                        slot_next = AW'(slot_sum - (AW + 1)'(RING_BYTES));
                    end
                    else
                    begin
                        slot_next = slot_sum[AW-1:0];
                    end
                    if (realign_sum >= (AW + 1)'(RING_BYTES))
                    begin
                        addr_next = AW'(realign_sum - (AW + 1)'(RING_BYTES));
                    end
                    else
                    begin
                        addr_next = realign_sum[AW-1:0];
                    end
                end
                else
                begin
                    step_next = step_reg + sbp_pkg::STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= sbp_pkg::STEP_PAYLOAD;
            count_reg     <= '0;
            addr_reg      <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
            slot_reg  <= slot_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg     <= emit_byte;
            out_addr_reg <= addr_reg;
            last_reg     <= emit_last;
        end
    end

    assign empty        = !out_valid_reg;
    assign data_byte    = data_reg;
    assign byte_address = out_addr_reg;
    assign last_of_run  = last_reg;

endmodule

@@ design/sample_byte_packetizer_top.sv @@
// Top level of the sample byte packetizer: front end, command queue, back end.
//
//  channel   handshake              payload
//  -------   ---------------------  -------------------------------------------
//  input     push / full            mode, sample_a, sample_b
//  result    empty / pop            data_byte, byte_address, last_of_run
//  config    cfg_valid / cfg_ready  cfg_data (selected channel)
//
//  An item is taken every cycle while the command queue has room; items that pack
//  nothing take no queue slot. The back end writes one byte per cycle unless the result
//  port stalls: a payload item gives one byte, a packet-closing item six (payload,
//  header, four trailer bytes). A clear item leaves the queue at once with no output.
//  Reset clears position, fill, count, address and selected channel; no clearing pass.
//  A stalled result port stops the back end only; the front keeps filling the queue.
`timescale 1ns / 1ps

module sample_byte_packetizer_top #(
    parameter int RING_BYTES    = sbp_pkg::RING_BYTES_DEFAULT,
    parameter int PAYLOAD_BYTES = sbp_pkg::PAYLOAD_BYTES_DEFAULT,
    parameter int CMD_DEPTH     = sbp_pkg::CMD_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        mode,
    input  logic signed [15:0]          sample_a,
    input  logic signed [15:0]          sample_b,
    input  logic                        pop,
    output logic                        empty,
    output logic [7:0]                  data_byte,
    output logic [sbp_pkg::ADDR_W-1:0]  byte_address,
    output logic                        last_of_run,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sbp_pkg::CHAN_W-1:0]  cfg_data
);

    logic [sbp_pkg::CHAN_W-1:0] channel_reg;
    logic                       cmd_wr;
    sbp_pkg::cmd_t              cmd_wr_data;
    logic                       cmd_rd;
    sbp_pkg::cmd_t              cmd_head;
    logic                       cmd_full;
    logic                       cmd_empty;
    logic                       mid_packet;

    assign cfg_ready = 1'b1;
    assign full      = cmd_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            channel_reg <= cfg_data;
        end
    end

    sbp_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .mode             (mode),
        .sample_a         (sample_a),
        .sample_b         (sample_b),
        .selected_channel (channel_reg),
        .cmd_full         (cmd_full),
        .cmd_wr           (cmd_wr),
        .cmd_data         (cmd_wr_data)
    );

    sbp_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_wr),
        .wr_data (cmd_wr_data),
        .rd      (cmd_rd),
        .rd_data (cmd_head),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    sbp_back #(
        .RING_BYTES (RING_BYTES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .selected_channel (channel_reg),
        .cmd_empty        (cmd_empty),
        .cmd_head         (cmd_head),
        .cmd_rd           (cmd_rd),
        .mid_packet       (mid_packet),
        .pop              (pop),
        .empty            (empty),
        .data_byte        (data_byte),
        .byte_address     (byte_address),
        .last_of_run      (last_of_run)
    );

    // Front must never issue into a full queue.
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_wr |-> !cmd_full)
        else $error("command issued into full queue");

    // A packet in progress keeps its command at the queue head.
    a_packet_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        mid_packet |-> (!cmd_empty && cmd_head.kind == sbp_pkg::CMD_PACKET))
        else $error("packet sequence without its command");

    // Within a run, the next byte follows the transfer without a gap.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_of_run) |=> !empty)
        else $error("run broken before its last byte");

endmodule
